@@ rtl/fwcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwcw_pkg
// Shared types and constants for the frame window crop writer: command codes,
// register indexes, geometry limits, the derived geometry and result bundles.
// ----------------------------------------------------------------------------
package fwcw_pkg;

    localparam int MAX_LINE_PIXELS = 2048;
    localparam int MAX_FRAME_LINES = 2048;
    localparam int LINE_BYTES_MAX  = 8191;
    localparam int FRAME_LINES_MAX = 4095;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int COL_W   = 13;
    localparam int LINE_W  = 12;
    localparam int FILL_W  = 24;
    localparam int IDLE_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int COLHI_W = 15;
    localparam int ROWHI_W = 13;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VIRTUAL_WIDTH   = 3'd0,
        REG_VISIBLE_WIDTH   = 3'd1,
        REG_X_START         = 3'd2,
        REG_VIRTUAL_HEIGHT  = 3'd3,
        REG_VISIBLE_HEIGHT  = 3'd4,
        REG_Y_START         = 3'd5,
        REG_BYTES_PER_PIXEL = 3'd6,
        REG_TIMEOUT_TICKS   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [COL_W-1:0]   line_len;
        logic [COL_W-1:0]   col_lo;
        logic [COLHI_W-1:0] col_hi;
        logic [10:0]        y_start;
        logic [ROWHI_W-1:0] row_hi;
        logic [LINE_W-1:0]  frame_lines;
        logic [IDLE_W-1:0]  timeout;
    } geom_t;

    typedef struct packed {
        logic              valid;
        logic              store;
        logic              buffer_index;
        logic [FILL_W-1:0] byte_address;
        logic [BYTE_W-1:0] data_out;
        logic              frame_done;
    } result_t;

endpackage : fwcw_pkg
`default_nettype wire

@@ rtl/fwcw_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwcw_cfg
// Configuration registers and the geometry derived from them: line length in
// bytes, visible column and line bounds, clamped frame height and timeout.
// ----------------------------------------------------------------------------
module fwcw_cfg
    import fwcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output geom_t                       geom
);

    logic [11:0]       virtual_width_reg;
    logic [11:0]       visible_width_reg;
    logic [10:0]       x_start_reg;
    logic [11:0]       virtual_height_reg;
    logic [11:0]       visible_height_reg;
    logic [10:0]       y_start_reg;
    logic [1:0]        bytes_per_pixel_reg;
    logic [IDLE_W-1:0] timeout_ticks_reg;

    logic              bpp3;
    logic [11:0]       vw_clamped;
    logic [11:0]       vh_clamped;
    logic [13:0]       line_bytes;
    logic [12:0]       x_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virtual_width_reg   <= 12'd640;
            visible_width_reg   <= 12'd640;
            x_start_reg         <= 11'd0;
            virtual_height_reg  <= 12'd480;
            visible_height_reg  <= 12'd480;
            y_start_reg         <= 11'd0;
            bytes_per_pixel_reg <= 2'd3;
            timeout_ticks_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_VIRTUAL_WIDTH:   virtual_width_reg   <= cfg_data[11:0];
                REG_VISIBLE_WIDTH:   visible_width_reg   <= cfg_data[11:0];
                REG_X_START:         x_start_reg         <= cfg_data[10:0];
                REG_VIRTUAL_HEIGHT:  virtual_height_reg  <= cfg_data[11:0];
                REG_VISIBLE_HEIGHT:  visible_height_reg  <= cfg_data[11:0];
                REG_Y_START:         y_start_reg         <= cfg_data[10:0];
                REG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[1:0];
                REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data[15:0];
                default:             timeout_ticks_reg   <= timeout_ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        bpp3 = (bytes_per_pixel_reg == 2'd3);

        vw_clamped = (virtual_width_reg > 12'(MAX_LINE_PIXELS)) ?
                     12'(MAX_LINE_PIXELS) : virtual_width_reg;
        vh_clamped = (virtual_height_reg > 12'(MAX_FRAME_LINES)) ?
                     12'(MAX_FRAME_LINES) : virtual_height_reg;
        if (vh_clamped > 12'(FRAME_LINES_MAX))
            vh_clamped = 12'(FRAME_LINES_MAX);

        line_bytes = {1'b0, vw_clamped, 1'b0} + (bpp3 ? {2'b00, vw_clamped} : 14'd0);
        if (line_bytes > 14'(LINE_BYTES_MAX))
            geom.line_len = COL_W'(LINE_BYTES_MAX);
        else
            geom.line_len = line_bytes[COL_W-1:0];

        geom.col_lo = {1'b0, x_start_reg, 1'b0}
                    + (bpp3 ? {2'b00, x_start_reg} : 13'd0);

        x_end = {2'b00, x_start_reg} + {1'b0, visible_width_reg};
        geom.col_hi = {1'b0, x_end, 1'b0} + (bpp3 ? {2'b00, x_end} : 15'd0);

        geom.y_start     = y_start_reg;
        geom.row_hi      = {2'b00, y_start_reg} + {1'b0, visible_height_reg};
        geom.frame_lines = vh_clamped;
        geom.timeout     = timeout_ticks_reg;
    end

endmodule : fwcw_cfg
`default_nettype wire

@@ rtl/fwcw_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwcw_step
// Position tracking for one command per cycle while go is high: column, line,
// fill count, idle counter, pending buffer, write-call flags, result fields.
// ----------------------------------------------------------------------------
module fwcw_step
    import fwcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last,
    input  wire geom_t             geom,
    output result_t                res
);

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              pending_reg, pending_next;
    logic              drop_reg, drop_next;
    logic              inw_reg, inw_next;

    logic [COL_W-1:0]  col_v;
    logic [COL_W-1:0]  col_inc;
    logic [LINE_W-1:0] line_v;
    logic [LINE_W-1:0] line_inc;
    logic [FILL_W-1:0] fill_v;
    logic              drop_v;
    logic              in_window;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            line_reg    <= '0;
            fill_reg    <= '0;
            idle_reg    <= '0;
            pending_reg <= 1'b0;
            drop_reg    <= 1'b0;
            inw_reg     <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            line_reg    <= line_next;
            fill_reg    <= fill_next;
            idle_reg    <= idle_next;
            pending_reg <= pending_next;
            drop_reg    <= drop_next;
            inw_reg     <= inw_next;
        end
    end

    always_comb
    begin
        col_next     = col_reg;
        line_next    = line_reg;
        fill_next    = fill_reg;
        idle_next    = idle_reg;
        pending_next = pending_reg;
        drop_next    = drop_reg;
        inw_next     = inw_reg;

        col_v     = col_reg;
        line_v    = line_reg;
        fill_v    = fill_reg;
        drop_v    = drop_reg;
        col_inc   = '0;
        line_inc  = '0;
        in_window = 1'b0;

        res              = '0;
        res.buffer_index = pending_reg;

        if (go)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (idle_reg != IDLE_MAX)
                        idle_next = idle_reg + 1'b1;
                end
                CMD_RESTART:
                begin
                    col_next  = '0;
                    line_next = '0;
                    fill_next = '0;
                    drop_next = 1'b0;
                    inw_next  = 1'b0;
                end
                CMD_DATA:
                begin
                    res.valid = 1'b1;
                    if (!inw_reg)
                    begin
                        // restart a partial frame after a long idle gap
                        if ((col_reg != '0 || line_reg != '0 || fill_reg != '0)
                            && idle_reg >= geom.timeout)
                        begin
                            col_v  = '0;
                            line_v = '0;
                            fill_v = '0;
                        end
                        idle_next = '0;
                        drop_v    = 1'b0;
                        inw_next  = 1'b1;
                    end

                    if (!drop_v && line_v < geom.frame_lines)
                    begin
                        in_window = ({1'b0, line_v} >= {2'b00, geom.y_start})
                                 && ({1'b0, line_v} < geom.row_hi)
                                 && (col_v >= geom.col_lo)
                                 && ({2'b00, col_v} < geom.col_hi);
                        if (in_window)
                        begin
                            res.store        = 1'b1;
                            res.byte_address = fill_v;
                            res.data_out     = data_byte;
                            fill_v           = fill_v + 1'b1;
                        end
                        col_inc = col_v + 1'b1;
                        if (col_inc >= geom.line_len)
                        begin
                            col_v    = '0;
                            line_inc = line_v + 1'b1;
                            if (line_inc >= geom.frame_lines)
                            begin
                                res.frame_done = 1'b1;
                                pending_next   = ~pending_reg;
                                line_v         = '0;
                                fill_v         = '0;
                                drop_v         = 1'b1;
                            end
                            else
                            begin
                                line_v = line_inc;
                            end
                        end
                        else
                        begin
                            col_v = col_inc;
                        end
                    end

                    if (last)
                    begin
                        inw_next = 1'b0;
                        drop_v   = 1'b0;
                    end

                    col_next  = col_v;
                    line_next = line_v;
                    fill_next = fill_v;
                    drop_next = drop_v;
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    a_done_swaps: assert property (@(posedge clk) disable iff (!rst_n)
        go && res.frame_done |=> pending_reg != $past(pending_reg))
        else $error("frame done without buffer swap");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && res.frame_done |=> col_reg == '0 && line_reg == '0 && fill_reg == '0)
        else $error("position not cleared at frame done");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd == CMD_RESTART |=> fill_reg == '0 && !inw_reg && !drop_reg
                                     && pending_reg == $past(pending_reg))
        else $error("restart did not clear position");

endmodule : fwcw_step
`default_nettype wire

@@ rtl/frame_window_crop_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_window_crop_writer
// Crops a virtual frame byte stream to a visible window and addresses the
// kept bytes sequentially in the pending one of two frame buffers.
// ----------------------------------------------------------------------------
// One command is taken every clock while the result side does not stall. Each
// transfer passes an input register, one pass of position logic and an output
// register, so a data byte's result reaches the result port from the output
// register; ticks, restarts and the unused code give no result. The rate is
// set by the position update, which carries column, line and fill count from
// one byte to the next. A stall on the result side holds one item in each
// register before input is refused.
// ----------------------------------------------------------------------------
module frame_window_crop_writer
    import fwcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // data_byte
    input  wire logic [1:0]             s_tuser,   // command
    input  wire logic                   s_tlast,   // end_of_write
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [31:0]            m_tdata,   // byte_address, data_out
    output      logic [1:0]             m_tuser,   // store, buffer_index
    output      logic                   m_tlast    // frame_done
);

    geom_t             geom;
    result_t           res;

    logic              in_valid_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    logic              out_store_reg;
    logic              out_buf_reg;
    logic [FILL_W-1:0] out_addr_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_done_reg;

    logic              out_free;
    logic              step_go;
    logic              in_take;

    assign out_free = !out_valid_reg || m_tready;
    assign step_go  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    fwcw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    fwcw_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (step_go),
        .cmd       (in_cmd_reg),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .geom      (geom),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= step_go && res.valid;
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step_go && res.valid)
        begin
            out_store_reg <= res.store;
            out_buf_reg   <= res.buffer_index;
            out_addr_reg  <= res.byte_address;
            out_data_reg  <= res.data_out;
            out_done_reg  <= res.frame_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg, out_addr_reg};
    assign m_tuser  = {out_buf_reg, out_store_reg};
    assign m_tlast  = out_done_reg;

endmodule : frame_window_crop_writer
`default_nettype wire

@@ verif/crop_window_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crop_window_checker
// Tracks the crop position, fill count and buffer selection of the frame
// window crop writer from the command transfers and register writes it sees,
// queues the store each data byte should produce and compares every result
// transfer field by field against the oldest queued store.
// ----------------------------------------------------------------------------
module crop_window_checker
    import fwcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // data_byte
    input  wire logic [1:0]             s_tuser,   // command
    input  wire logic                   s_tlast,   // end_of_write
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [31:0]            m_tdata,   // byte_address, data_out
    input  wire logic [1:0]             m_tuser,   // store, buffer_index
    input  wire logic                   m_tlast,   // frame_done
    output int                          mismatches,
    output int                          outstanding,
    output int                          stored_bytes,
    output int                          frames_done
);

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic              store;
        logic              buffer_index;
        logic [FILL_W-1:0] byte_address;
        logic [BYTE_W-1:0] data_out;
        logic              frame_done;
    } crop_write_t;

    crop_write_t expected_writes[$];

    logic [11:0] virt_width;
    logic [11:0] vis_width;
    logic [10:0] x_first;
    logic [11:0] virt_height;
    logic [11:0] vis_height;
    logic [10:0] y_first;
    logic [1:0]  pixel_bytes;
    logic [15:0] idle_limit;

    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic [FILL_W-1:0] fill;
    logic [IDLE_W-1:0] idle_ticks;
    logic              pending_buf;
    logic              skip_rest;
    logic              in_call;
    int                reports;

    function automatic void clear_position();
        column = '0;
        line   = '0;
        fill   = '0;
    endfunction

    function automatic void write_shadow(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_VIRTUAL_WIDTH:   virt_width  = value[11:0];
            REG_VISIBLE_WIDTH:   vis_width   = value[11:0];
            REG_X_START:         x_first     = value[10:0];
            REG_VIRTUAL_HEIGHT:  virt_height = value[11:0];
            REG_VISIBLE_HEIGHT:  vis_height  = value[11:0];
            REG_Y_START:         y_first     = value[10:0];
            REG_BYTES_PER_PIXEL: pixel_bytes = value[1:0];
            default:             idle_limit  = value;
        endcase
    endfunction

    function automatic void advance_position(input logic [1:0] code,
                                             input logic [7:0] value,
                                             input logic last);
        crop_write_t w;
        int bpp, vw, vh, line_len, col_lo, col_hi, row_hi;
        w = '0;
        w.buffer_index = pending_buf;
        case (code)
            CMD_TICK:
            begin
                if (idle_ticks != IDLE_MAX)
                    idle_ticks = idle_ticks + 1'b1;
            end
            CMD_RESTART:
            begin
                clear_position();
                skip_rest = 1'b0;
                in_call   = 1'b0;
            end
            CMD_DATA:
            begin
                if (!in_call)
                begin
                    if ((column != 0 || line != 0 || fill != 0) && idle_ticks >= idle_limit)
                        clear_position();
                    idle_ticks = '0;
                    skip_rest  = 1'b0;
                    in_call    = 1'b1;
                end
                bpp = (pixel_bytes == 2'd3) ? 3 : 2;
                vw  = (int'(virt_width) > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : int'(virt_width);
                vh  = (int'(virt_height) > MAX_FRAME_LINES) ? MAX_FRAME_LINES : int'(virt_height);
                line_len = vw * bpp;
                if (line_len > LINE_BYTES_MAX)
                    line_len = LINE_BYTES_MAX;
                if (vh > FRAME_LINES_MAX)
                    vh = FRAME_LINES_MAX;
                col_lo = int'(x_first) * bpp;
                col_hi = (int'(x_first) + int'(vis_width)) * bpp;
                row_hi = int'(y_first) + int'(vis_height);
                if (!skip_rest && int'(line) < vh)
                begin
                    if (int'(line) >= int'(y_first) && int'(line) < row_hi &&
                        int'(column) >= col_lo && int'(column) < col_hi)
                    begin
                        w.store        = 1'b1;
                        w.byte_address = fill;
                        w.data_out     = value;
                        fill           = fill + 1'b1;
                    end
                    column = column + 1'b1;
                    if (int'(column) >= line_len)
                    begin
                        column = '0;
                        line   = line + 1'b1;
                        if (int'(line) >= vh)
                        begin
                            w.frame_done = 1'b1;
                            pending_buf  = ~pending_buf;
                            clear_position();
                            skip_rest = 1'b1;
                        end
                    end
                end
                if (last)
                begin
                    in_call   = 1'b0;
                    skip_rest = 1'b0;
                end
                expected_writes.push_back(w);
            end
            default: ;
        endcase
    endfunction

    function automatic void report_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (reports < REPORT_CAP)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
                         want, got);
            reports++;
        end
    endfunction

    function automatic void check_result();
        crop_write_t want, got;
        got.store        = m_tuser[0];
        got.buffer_index = m_tuser[1];
        got.byte_address = m_tdata[23:0];
        got.data_out     = m_tdata[31:24];
        got.frame_done   = m_tlast;
        if (expected_writes.size() == 0)
        begin
            mismatches++;
            if (reports < REPORT_CAP)
                $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                         $time, got);
            reports++;
        end
        else
        begin
            want = expected_writes.pop_front();
            report_field("store", want.store, got.store);
            report_field("buffer_index", want.buffer_index, got.buffer_index);
            report_field("byte_address", want.byte_address, got.byte_address);
            report_field("data_out", want.data_out, got.data_out);
            report_field("frame_done", want.frame_done, got.frame_done);
            if (want.store)
                stored_bytes++;
            if (want.frame_done)
                frames_done++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virt_width   = 12'd640;
            vis_width    = 12'd640;
            x_first      = '0;
            virt_height  = 12'd480;
            vis_height   = 12'd480;
            y_first      = '0;
            pixel_bytes  = 2'd3;
            idle_limit   = 16'd1000;
            clear_position();
            idle_ticks   = '0;
            pending_buf  = 1'b0;
            skip_rest    = 1'b0;
            in_call      = 1'b0;
            expected_writes.delete();
            mismatches   = 0;
            outstanding  = 0;
            stored_bytes = 0;
            frames_done  = 0;
            reports      = 0;
        end
        else
        begin
            if (cfg_we)
                write_shadow(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                advance_position(s_tuser, s_tdata, s_tlast);
            outstanding = expected_writes.size();
        end
    end

endmodule : crop_window_checker

@@ verif/frame_window_crop_writer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_window_crop_writer_tb
// Drives write calls, idle ticks, restarts and noise into the frame window
// crop writer under a series of window geometries, with random gaps on the
// command side and random stalls on the result side. A checker beside the
// block predicts every store and reports mismatches; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module frame_window_crop_writer_tb;
    import fwcw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 72;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    int mismatches;
    int outstanding;
    int stored_bytes;
    int frames_done;

    bit calm = 1'b1;
    int items_sent;
    int bytes_sent;
    int ticks_sent;
    int restarts_sent;
    int phase_items;
    int tick_span;

    frame_window_crop_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    crop_window_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .stored_bytes (stored_bytes),
        .frames_done  (frames_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 11) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] code, input logic [7:0] value,
                             input logic last);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (code != CMD_UNUSED)
        begin
            items_sent++;
            phase_items++;
        end
        case (code)
            CMD_DATA:    bytes_sent++;
            CMD_TICK:    ticks_sent++;
            CMD_RESTART: restarts_sent++;
            default: ;
        endcase
    endtask

    // hold off until every queued store has come back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value, input int width);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? ($urandom << width) : 32'd0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(junk | value);
        @(posedge clk);
    endtask

    task automatic load_geometry(input int phase);
        int vw, visw, xs, vh, vish, ys, bpp, tmo;
        case (phase)
            0:
            begin
                vw = 0; visw = 1; xs = 0; vh = 3; vish = 4095; ys = 0; bpp = 0; tmo = 0;
            end
            1:
            begin
                vw = 4095; visw = 4095; xs = 2047; vh = 4095; vish = 4095; ys = 2047;
                bpp = 3; tmo = 65535;
            end
            2:
            begin
                vw = 2; visw = 0; xs = 2047; vh = 0; vish = 0; ys = 0; bpp = 1; tmo = 1;
            end
            default:
            begin
                vw   = $urandom_range(1, 6);
                visw = $urandom_range(0, 8);
                xs   = $urandom_range(0, 4);
                vh   = $urandom_range(1, 5);
                vish = $urandom_range(0, 6);
                ys   = $urandom_range(0, 3);
                bpp  = $urandom_range(0, 3);
                tmo  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 65535)
                                                   : $urandom_range(0, 5);
            end
        endcase
        write_reg(REG_VIRTUAL_WIDTH, vw, 12);
        write_reg(REG_VISIBLE_WIDTH, visw, 12);
        write_reg(REG_X_START, xs, 11);
        write_reg(REG_VIRTUAL_HEIGHT, vh, 12);
        write_reg(REG_VISIBLE_HEIGHT, vish, 12);
        write_reg(REG_Y_START, ys, 11);
        write_reg(REG_BYTES_PER_PIXEL, bpp, 2);
        write_reg(REG_TIMEOUT_TICKS, tmo, 16);
        cfg_we <= 1'b0;
        tick_span = (tmo < 8) ? tmo + 2 : 6;
    endtask

    task automatic run_sequence();
        int pick, len;
        pick = $urandom_range(0, 19);
        if (pick < 13)
        begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
                send_item(CMD_DATA, 8'($urandom), i == len - 1);
        end
        else if (pick < 17)
        begin
            len = $urandom_range(1, tick_span);
            for (int i = 0; i < len; i++)
                send_item(CMD_TICK, 8'($urandom), 1'($urandom));
        end
        else if (pick == 17)
            send_item(CMD_RESTART, 8'($urandom), 1'($urandom));
        else if (pick == 18)
            send_item(CMD_UNUSED, 8'($urandom), 1'($urandom));
        else
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);

        // reset geometry: a partial frame with ticks inside and between calls
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hFF, 1'b0);
        send_item(CMD_TICK, 8'hFF, 1'b1);
        send_item(CMD_UNUSED, 8'hFF, 1'b1);
        send_item(CMD_DATA, 8'hA5, 1'b1);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'h5A, 1'b1);
        send_item(CMD_RESTART, 8'hFF, 1'b1);
        send_item(CMD_DATA, 8'hFF, 1'b1);
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_RESTART, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'h81, 1'b0);
        send_item(CMD_DATA, 8'h7E, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            calm = (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
            load_geometry(phase);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                run_sequence();
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d commands over %0d geometries: %0d data bytes, %0d ticks, %0d restarts.",
                 items_sent, PHASES + 1, bytes_sent, ticks_sent, restarts_sent);
        $display("Checked %0d stored bytes and %0d completed frames.", stored_bytes,
                 frames_done);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : frame_window_crop_writer_tb
